>>> hdl/octree_morton_cell_index_core_assert.svh
// Assertion macros for the octree Morton cell index core
`ifndef OCTREE_MORTON_CELL_INDEX_CORE_ASSERT_SVH
`define OCTREE_MORTON_CELL_INDEX_CORE_ASSERT_SVH
`ifndef SYNTH
`define OMCI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("omci assertion failed");
`define OMCI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("omci assertion failed");
`else
`define OMCI_ASSERT_IMP(lbl, ante, cons)
`define OMCI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/omci_pkg.sv
// Shared constants, types and functions of the octree Morton cell index core
package omci_pkg;

  localparam int unsigned MAX_DEPTH = 7;
  localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned GRID_W    = MAX_DEPTH;
  localparam int unsigned CODE_W    = 3 * MAX_DEPTH;
  localparam int unsigned SH_W      = DEPTH_W + 2;
  localparam int unsigned NUM_LANES = 6;

  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned NUMBER_W  = 21;
  localparam int unsigned INDEX_W   = 22;
  localparam int unsigned IN_W      = 192;
  localparam int unsigned OUT_W     = 48;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_INV_CELL_X = 3'd3,
    REG_INV_CELL_Y = 3'd4,
    REG_INV_CELL_Z = 3'd5,
    REG_DEPTH      = 3'd6
  } omci_reg_t;

  localparam logic [31:0] INV_CELL_RST = 32'h0001_0000;
  localparam logic [2:0]  DEPTH_RST    = 3'd7;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } omci_en_t;

  // largest cell coordinate at a given depth
  function automatic logic [GRID_W-1:0] grid_top(input logic [DEPTH_W-1:0] d);
    logic [GRID_W-1:0] t;
    t = '0;
    for (int k = 0; k < GRID_W; k++) begin
      if (k < d) t[k] = 1'b1;
    end
    return t;
  endfunction

  // (8^lvl - 1) / 7
  function automatic logic [CODE_W-1:0] level_base(input logic [DEPTH_W-1:0] lvl);
    logic [CODE_W-1:0] b;
    b = '0;
    for (int k = 0; k < MAX_DEPTH; k++) begin
      if (k < lvl) b[3*k] = 1'b1;
    end
    return b;
  endfunction

endpackage

>>> hdl/omci_lane.sv
// One coordinate lane: offset, reciprocal multiply, floor and clamp to the grid
module omci_lane import omci_pkg::*; (
  input  logic               clk,
  input  omci_en_t           en,
  input  logic [31:0]        corner,
  input  logic [31:0]        origin,
  input  logic [31:0]        inv_cell,
  input  logic [DEPTH_W-1:0] depth,
  output logic [GRID_W-1:0]  grid_cell,
  output logic               clamp
);

  logic [32:0]       off;
  logic [31:0]       mag_r;
  logic              neg_r;
  logic [63:0]       prod;
  logic [31:0]       hi_r;
  logic              neg2_r;
  logic [GRID_W-1:0] top;
  logic [GRID_W-1:0] cell_r, cell_nxt;
  logic              clamp_r, clamp_nxt;

  assign off  = {corner[31], corner} - {origin[31], origin};
  assign prod = {32'd0, mag_r} * {32'd0, inv_cell};
  assign top  = grid_top(depth);

  always_comb begin
    cell_nxt  = hi_r[GRID_W-1:0];
    clamp_nxt = 1'b0;
    if (neg2_r) begin
      cell_nxt  = '0;
      clamp_nxt = 1'b1;
    end else if (hi_r > 32'(top)) begin
      cell_nxt  = top;
      clamp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mag_r <= off[31:0];
      neg_r <= off[32];
    end
    if (en.s2) begin
      hi_r   <= prod[63:32];
      neg2_r <= neg_r;
    end
    if (en.s3) begin
      cell_r  <= cell_nxt;
      clamp_r <= clamp_nxt;
    end
  end

  assign grid_cell = cell_r;
  assign clamp     = clamp_r;

endmodule

>>> hdl/omci_merge.sv
// Merge of the lane results: Morton interleave, level search, linear index
module omci_merge import omci_pkg::*; (
  input  logic               clk,
  input  omci_en_t           en,
  input  logic [GRID_W-1:0]  cells [NUM_LANES],
  input  logic [NUM_LANES-1:0] clamps,
  input  logic [DEPTH_W-1:0] depth,
  output logic [LEVEL_W-1:0] cell_level,
  output logic [NUMBER_W-1:0] cell_number,
  output logic [INDEX_W-1:0] cell_index,
  output logic               clamped
);

  logic [CODE_W-1:0]   e1, e2, diff;
  logic [DEPTH_W-1:0]  shift;
  logic [SH_W-1:0]     sh3;
  logic [DEPTH_W-1:0]  level_r;
  logic [CODE_W-1:0]   number_r;
  logic                flag_r;
  logic [CODE_W:0]     idx_sum;
  logic [LEVEL_W-1:0]  level_o_r;
  logic [NUMBER_W-1:0] number_o_r;
  logic [INDEX_W-1:0]  index_o_r;
  logic                flag_o_r;

  always_comb begin
    e1 = '0;
    e2 = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      e1[3*i]   = cells[0][i];
      e1[3*i+1] = cells[1][i];
      e1[3*i+2] = cells[2][i];
      e2[3*i]   = cells[3][i];
      e2[3*i+1] = cells[4][i];
      e2[3*i+2] = cells[5][i];
    end
    diff  = e1 ^ e2;
    shift = '0;
    for (int g = 0; g < MAX_DEPTH; g++) begin
      if (|diff[3*g +: 3]) shift = DEPTH_W'(g + 1);
    end
    sh3 = SH_W'(shift) * SH_W'(3);
  end

  assign idx_sum = {1'b0, level_base(level_r)} + {1'b0, number_r};

  always_ff @(posedge clk) begin
    if (en.s4) begin
      level_r  <= depth - shift;
      number_r <= e1 >> sh3;
      flag_r   <= |clamps;
    end
    if (en.s5) begin
      level_o_r  <= LEVEL_W'(level_r);
      number_o_r <= NUMBER_W'(number_r);
      index_o_r  <= INDEX_W'(idx_sum);
      flag_o_r   <= flag_r;
    end
  end

  assign cell_level  = level_o_r;
  assign cell_number = number_o_r;
  assign cell_index  = index_o_r;
  assign clamped     = flag_o_r;

endmodule

>>> hdl/octree_morton_cell_index_core.sv
// Top level: config registers, six quantizing lanes, merge stage, stream handshake
// Pipeline: five register stages from input beat to result valid (offset, multiply, clamp, merge, index).
// Throughput: one box per cycle while out_tready is high; a full stage stalls only when its successor stalls.
// The six 32x32 reciprocal multipliers, one per lane, set the stage between register pairs.
// Reset (rst_n, synchronous) empties the pipeline and restores the config registers:
// origins 0, reciprocals 1.0, depth 7.
module octree_morton_cell_index_core import omci_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // cell_level, cell_number, cell_index, clamped, pad
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  `include "octree_morton_cell_index_core_assert.svh"

  logic [31:0]          origin_r [3];
  logic [31:0]          inv_r [3];
  logic [2:0]           depth_in_use_r;
  logic [DEPTH_W-1:0]   depth_d;
  logic                 cfg_wr;
  omci_reg_t            cfg_reg;

  logic [4:0]           v_r;
  omci_en_t             en;

  logic [GRID_W-1:0]    cells [NUM_LANES];
  logic [NUM_LANES-1:0] clamps;
  logic [LEVEL_W-1:0]   cell_level;
  logic [NUMBER_W-1:0]  cell_number;
  logic [INDEX_W-1:0]   cell_index;
  logic                 clamped;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_reg    = omci_reg_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0]    <= '0;
      origin_r[1]    <= '0;
      origin_r[2]    <= '0;
      inv_r[0]       <= INV_CELL_RST;
      inv_r[1]       <= INV_CELL_RST;
      inv_r[2]       <= INV_CELL_RST;
      depth_in_use_r <= DEPTH_RST;
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_ORIGIN_X:   origin_r[0]    <= cfg_pwdata;
        REG_ORIGIN_Y:   origin_r[1]    <= cfg_pwdata;
        REG_ORIGIN_Z:   origin_r[2]    <= cfg_pwdata;
        REG_INV_CELL_X: inv_r[0]       <= cfg_pwdata;
        REG_INV_CELL_Y: inv_r[1]       <= cfg_pwdata;
        REG_INV_CELL_Z: inv_r[2]       <= cfg_pwdata;
        REG_DEPTH:      depth_in_use_r <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_ORIGIN_X:   cfg_prdata = origin_r[0];
      REG_ORIGIN_Y:   cfg_prdata = origin_r[1];
      REG_ORIGIN_Z:   cfg_prdata = origin_r[2];
      REG_INV_CELL_X: cfg_prdata = inv_r[0];
      REG_INV_CELL_Y: cfg_prdata = inv_r[1];
      REG_INV_CELL_Z: cfg_prdata = inv_r[2];
      REG_DEPTH:      cfg_prdata = {29'd0, depth_in_use_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign depth_d = (32'(depth_in_use_r) > 32'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
                                                          : DEPTH_W'(depth_in_use_r);

  // stage valids; a stage advances when empty or when the next one advances
  assign en.s5     = ~v_r[4] | out_tready;
  assign en.s4     = ~v_r[3] | en.s5;
  assign en.s3     = ~v_r[2] | en.s4;
  assign en.s2     = ~v_r[1] | en.s3;
  assign en.s1     = ~v_r[0] | en.s2;
  assign in_tready = en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en.s1) v_r[0] <= in_tvalid;
      if (en.s2) v_r[1] <= v_r[0];
      if (en.s3) v_r[2] <= v_r[1];
      if (en.s4) v_r[3] <= v_r[2];
      if (en.s5) v_r[4] <= v_r[3];
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    omci_lane u_lane (
      .clk       (clk),
      .en        (en),
      .corner    (in_tdata[32*i +: 32]),
      .origin    (origin_r[i % 3]),
      .inv_cell  (inv_r[i % 3]),
      .depth     (depth_d),
      .grid_cell (cells[i]),
      .clamp     (clamps[i])
    );
  end

  omci_merge u_merge (
    .clk         (clk),
    .en          (en),
    .cells       (cells),
    .clamps      (clamps),
    .depth       (depth_d),
    .cell_level  (cell_level),
    .cell_number (cell_number),
    .cell_index  (cell_index),
    .clamped     (clamped)
  );

  assign out_tvalid = v_r[4];
  assign out_tdata  = {1'b0, clamped, cell_index, cell_number, cell_level};

  `OMCI_ASSERT_IMP(a_stall_full, !in_tready, &v_r)
  `OMCI_ASSERT_IMP(a_level_in_depth, out_tvalid, 32'(cell_level) <= 32'(depth_d))
  `OMCI_ASSERT_IMP(a_root_cell, out_tvalid && cell_level == '0,
                   cell_number == '0 && cell_index == '0)

endmodule

>>> tb/octree_morton_cell_index_core_tb.sv
// Self-checking testbench for the octree Morton cell index core
module octree_morton_cell_index_core_tb;
  import omci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned REG_UNMAPPED = 7;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [NUMBER_W-1:0] number;
    logic [INDEX_W-1:0]  index;
    logic                clamped;
  } placement_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;      // cell_level, cell_number, cell_index, clamped, pad
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // shadow of the register file
  logic [31:0] org_reg [3];
  logic [31:0] inv_reg [3];
  logic [2:0]  depth_reg;

  logic [IN_W-1:0] box_q [$];
  placement_t      placement_q [$];
  placement_t      want, got;
  int unsigned     errors = 0;
  int unsigned     cycles = 0;
  bit              calm = 1'b0;

  octree_morton_cell_index_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  function automatic placement_t locate_cell(input logic [IN_W-1:0] box);
    placement_t        p;
    int unsigned       dep, shift, lvl, a;
    logic [31:0]       corner;
    logic signed [32:0] off;
    logic [63:0]       prod, gridv, top;
    logic [63:0]       q [6];
    logic [63:0]       e1, e2, diff, num, base;
    logic              flag;
    dep = (depth_reg > MAX_DEPTH) ? MAX_DEPTH : depth_reg;
    top = (64'd1 << dep) - 64'd1;
    flag = 1'b0;
    for (int c = 0; c < 6; c++) begin
      a = c % 3;
      corner = box[32*c +: 32];
      off = $signed({corner[31], corner}) - $signed({org_reg[a][31], org_reg[a]});
      if (off < 0) begin
        flag = 1'b1;
        q[c] = '0;
      end else begin
        prod = {32'd0, off[31:0]} * {32'd0, inv_reg[a]};
        gridv = {32'd0, prod[63:32]};
        if (gridv > top) begin
          flag = 1'b1;
          gridv = top;
        end
        q[c] = gridv;
      end
    end
    e1 = '0;
    e2 = '0;
    for (int i = 0; i < dep; i++) begin
      e1[3*i]   = q[0][i];
      e1[3*i+1] = q[1][i];
      e1[3*i+2] = q[2][i];
      e2[3*i]   = q[3][i];
      e2[3*i+1] = q[4][i];
      e2[3*i+2] = q[5][i];
    end
    diff = e1 ^ e2;
    shift = 0;
    for (int g = 0; g < dep; g++) begin
      if (((diff >> (3*g)) & 64'd7) != 0) shift = g + 1;
    end
    lvl = dep - shift;
    num = e1 >> (3*shift);
    base = ((64'd1 << (3*lvl)) - 64'd1) / 64'd7;
    p.level = lvl[LEVEL_W-1:0];
    p.number = num[NUMBER_W-1:0];
    p.index = INDEX_W'(base + num);
    p.clamped = flag;
    return p;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (box_q.size() > 0 && (calm || $urandom_range(0, 99) >= 6)) begin
        in_tvalid <= 1'b1;
        in_tdata <= box_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink backpressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= calm || ($urandom_range(0, 99) >= 6);
  end

  // monitor: predict on input beats, check on output beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) placement_q.push_back(locate_cell(in_tdata));
      if (out_tvalid && out_tready) begin
        got.level = out_tdata[2:0];
        got.number = out_tdata[23:3];
        got.index = out_tdata[45:24];
        got.clamped = out_tdata[46];
        if (placement_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: level %0d number %0d index %0d clamped %0b",
                     got.level, got.number, got.index, got.clamped);
        end else begin
          want = placement_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: level %0d/%0d number %0d/%0d index %0d/%0d ",
                        "clamped %0b/%0b (exp/act)"},
                       want.level, got.level, want.number, got.number,
                       want.index, got.index, want.clamped, got.clamped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input int unsigned idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(idx * 4);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_ORIGIN_X:   org_reg[0] = val;
      REG_ORIGIN_Y:   org_reg[1] = val;
      REG_ORIGIN_Z:   org_reg[2] = val;
      REG_INV_CELL_X: inv_reg[0] = val;
      REG_INV_CELL_Y: inv_reg[1] = val;
      REG_INV_CELL_Z: inv_reg[2] = val;
      REG_DEPTH:      depth_reg = val[2:0];
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_space(input logic [31:0] ox, oy, oz, ix, iy, iz, input logic [2:0] d);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_INV_CELL_X, ix);
    write_reg(REG_INV_CELL_Y, iy);
    write_reg(REG_INV_CELL_Z, iz);
    write_reg(REG_DEPTH, {29'd0, d});
  endtask

  task automatic push_box(input logic [31:0] lx, ly, lz, hx, hy, hz);
    box_q.push_back({hz, hy, hx, lz, ly, lx});
  endtask

  // sampled away from the active edge so queue and handshake state have settled
  task automatic wait_idle();
    do @(negedge clk); while (box_q.size() != 0 || in_tvalid || placement_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly boxes inside root space, some straddling it, some pure noise
  task automatic add_random_boxes(input int n);
    logic [31:0] corner [6];
    logic [31:0] tmp;
    logic [63:0] span, off, sz, part;
    int unsigned r, dep;
    dep = (depth_reg > MAX_DEPTH) ? MAX_DEPTH : depth_reg;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      for (int a = 0; a < 3; a++) begin
        if (r < 12) begin
          corner[a] = $urandom;
          corner[a+3] = $urandom;
        end else begin
          if (inv_reg[a] == 0) span = 64'h1_0000_0000;
          else span = (64'd1 << (dep + 32)) / {32'd0, inv_reg[a]};
          if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
          if (span == 0) span = 64'd1;
          off = {$urandom, $urandom} % span;
          part = span >> $urandom_range(0, 10);
          sz = (part != 0) ? ({$urandom, $urandom} % part) : 64'd0;
          corner[a] = org_reg[a] + off[31:0];
          corner[a+3] = corner[a] + sz[31:0];
          if (r < 24 && $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1)) corner[a] = org_reg[a] - $urandom_range(1, 65536);
            else corner[a+3] = org_reg[a] + span[31:0] + $urandom_range(0, 65536);
          end
        end
      end
      if (r >= 12 && r < 16) begin
        for (int a = 0; a < 3; a++) begin
          tmp = corner[a];
          corner[a] = corner[a+3];
          corner[a+3] = tmp;
        end
      end
      push_box(corner[0], corner[1], corner[2], corner[3], corner[4], corner[5]);
    end
  endtask

  initial begin
    org_reg[0] = '0;
    org_reg[1] = '0;
    org_reg[2] = '0;
    inv_reg[0] = INV_CELL_RST;
    inv_reg[1] = INV_CELL_RST;
    inv_reg[2] = INV_CELL_RST;
    depth_reg = DEPTH_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: unit cells, 128 per axis
    push_box(0, 0, 0, 0, 0, 0);
    push_box(32'h007F_8000, 32'h007F_8000, 32'h007F_8000,
             32'h007F_8000, 32'h007F_8000, 32'h007F_8000);
    push_box(0, 0, 0, 32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF);
    push_box(0, 0, 0, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000);   // far boundary
    push_box(32'hFFFF_0000, 0, 0, 32'h0001_0000, 0, 0);               // below origin
    push_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_box(32'h0064_0000, 32'h0064_0000, 32'h0064_0000,
             32'h0003_0000, 32'h0003_0000, 32'h0003_0000);            // inverted
    push_box(32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
             32'h0003_0000, 32'h0003_0000, 32'h0003_0000);
    push_box(32'h0040_0000, 0, 0, 32'h003F_0000, 0, 0);
    push_box(0, 0, 0, 0, Q_ONE, 0);
    push_box(0, 0, 32'h0040_0000, 0, 0, 32'h0040_FFFF);
    add_random_boxes(90);
    wait_idle();

    calm = 1'b1;
    set_space(32'hFFFA_8000, 32'h0003_0000, 32'hFFFF_0000,
              32'h0004_0000, 32'h0004_0000, 32'h0002_0000, 3'd5);
    write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
    add_random_boxes(90);
    wait_idle();
    calm = 1'b0;

    // depth zero, reciprocal extremes, origin extremes
    set_space(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
              32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 3'd0);
    push_box(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_box(32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    add_random_boxes(40);
    wait_idle();

    write_reg(REG_DEPTH, 32'd7);
    push_box(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_007F, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_random_boxes(60);
    wait_idle();

    set_space($urandom, $urandom, $urandom, 32'h0000_2000, 32'h0000_1000, 32'h0000_4000, 3'd3);
    add_random_boxes(90);
    wait_idle();

    set_space(0, 0, 0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 3'd1);
    add_random_boxes(60);
    wait_idle();

    set_space($urandom_range(0, 32'h00FF_FFFF), $urandom, $urandom_range(0, 32'h00FF_FFFF),
              $urandom_range(32'h1000, 32'h10_0000), $urandom_range(32'h1000, 32'h10_0000),
              $urandom_range(32'h1000, 32'h10_0000), 3'd7);
    add_random_boxes(110);
    wait_idle();

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/omci_pkg.sv
hdl/omci_lane.sv
hdl/omci_merge.sv
hdl/octree_morton_cell_index_core.sv
tb/octree_morton_cell_index_core_tb.sv
